>>> sv/pnl_pkg.sv
package pnl_pkg;

   // Register map
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic CsrIdxLinkMode  = 1'b0;
   localparam logic CsrIdxSpinLimit = 1'b1;

   localparam logic        LinkModeReset  = 1'b0;
   localparam logic [15:0] SpinLimitReset = 16'd500;

   // Request commands
   localparam logic [1:0] CmdSend    = 2'd0;
   localparam logic [1:0] CmdReceive = 2'd1;
   localparam logic [1:0] CmdSample  = 2'd2;
   localparam logic [1:0] CmdFinish  = 2'd3;

   // Result events
   localparam logic [2:0] EvNone    = 3'd0;
   localparam logic [2:0] EvTxDone  = 3'd1;
   localparam logic [2:0] EvRxDone  = 3'd2;
   localparam logic [2:0] EvTimeout = 3'd3;
   localparam logic [2:0] EvFrameEnd = 3'd4;
   localparam logic [2:0] EvBusy    = 3'd5;

   // Handshake phase, one-hot
   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_TX_A = 5'b00010,
      PH_TX_B = 5'b00100,
      PH_RX_A = 5'b01000,
      PH_RX_B = 5'b10000
   } phase_type;

   // Configuration handed from the register block to the engine
   typedef struct packed {
      logic        link_mode;
      logic [15:0] spin_limit;
   } cfg_type;

   // Nibble encodings, BSD mode
   function automatic logic [7:0] bsd_tx_high(input logic [7:0] b);
      bsd_tx_high = {3'b000, b[7], 1'b1, b[6:4]};
   endfunction

   function automatic logic [7:0] bsd_tx_low(input logic [7:0] b);
      bsd_tx_low = {3'b000, b[3], 1'b0, b[2:0]};
   endfunction

   // Nibble encodings, compatible mode
   function automatic logic [7:0] cmp_tx_high(input logic [7:0] b);
      cmp_tx_high = {4'h0, b[7:4]};
   endfunction

   function automatic logic [7:0] cmp_tx_low(input logic [7:0] b);
      cmp_tx_low = {4'h1, b[3:0]};
   endfunction

   // Reassemble a received byte from its two status samples
   function automatic logic [7:0] bsd_rx(input logic [7:0] s1, input logic [7:0] s2);
      bsd_rx = {~s1[7], s1[5:3], ~s2[7], s2[5:3]};
   endfunction

   function automatic logic [7:0] cmp_rx(input logic [7:0] s1, input logic [7:0] s2);
      cmp_rx = {s2[6:3], s1[6:3]};
   endfunction

endpackage

>>> sv/pnl_csr.sv
module pnl_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pnl_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [pnl_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [pnl_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                  csr_pready,
   output pnl_pkg::cfg_type                      cfg
);

   pnl_pkg::cfg_type cfg_ff;
   pnl_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            pnl_pkg::CsrIdxLinkMode:  cfg_in.link_mode  = csr_pwdata[0];
            pnl_pkg::CsrIdxSpinLimit: cfg_in.spin_limit = csr_pwdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_mode  <= pnl_pkg::LinkModeReset;
         cfg_ff.spin_limit <= pnl_pkg::SpinLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (csr_paddr[2])
         pnl_pkg::CsrIdxLinkMode:  csr_prdata = {31'd0, cfg_ff.link_mode};
         pnl_pkg::CsrIdxSpinLimit: csr_prdata = {16'd0, cfg_ff.spin_limit};
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/pnl_engine.sv
module pnl_engine (
   input  logic             clock,
   input  logic             reset,
   input  pnl_pkg::cfg_type cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // tx_byte[7:0], status_lines[15:8]
   input  logic [1:0]       req_tuser,   // command[1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata    // drive_valid[0], drive_data[8:1],
                                         // event_res[11:9], rx_byte[19:12], zero fill
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] cmd_ff;
   logic [7:0] txb_ff, st_ff;

   // Link state
   pnl_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  first_ff, first_in;
   logic [15:0] poll_ff, poll_in;
   logic [7:0]  last_sent_ff, last_sent_in;
   logic        sent_any_ff, sent_any_in;
   logic [7:0]  last_second_ff, last_second_in;
   logic        recv_any_ff, recv_any_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff;

   // Step results
   logic        step_dv;
   logic [7:0]  step_dd;
   logic [2:0]  step_ev;
   logic [7:0]  step_rb;
   logic        cmp, shake, ok, ended;
   logic [15:0] poll_dec;
   logic        adv;

   // Handshake: advance when the result slot is free or being drained
   assign adv        = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | adv;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign cmp      = cfg.link_mode;
   assign shake    = cmp ? st_ff[7] : st_ff[6];
   assign poll_dec = poll_ff - 16'd1;

   // One step of the link handshake
   always_comb begin
      phase_in       = phase_ff;
      held_in        = held_ff;
      first_in       = first_ff;
      poll_in        = poll_ff;
      last_sent_in   = last_sent_ff;
      sent_any_in    = sent_any_ff;
      last_second_in = last_second_ff;
      recv_any_in    = recv_any_ff;
      step_dv        = 1'b0;
      step_dd        = 8'h00;
      step_ev        = pnl_pkg::EvNone;
      step_rb        = 8'h00;
      ok             = 1'b0;
      ended          = 1'b0;

      if (cmd_ff != pnl_pkg::CmdSample) begin
         if (phase_ff != pnl_pkg::PH_IDLE) begin
            step_ev = pnl_pkg::EvBusy;
         end else begin
            case (cmd_ff)
               pnl_pkg::CmdSend: begin
                  held_in      = txb_ff;
                  last_sent_in = txb_ff;
                  sent_any_in  = 1'b1;
                  step_dv      = 1'b1;
                  step_dd      = cmp ? pnl_pkg::cmp_tx_low(txb_ff)
                                     : pnl_pkg::bsd_tx_high(txb_ff);
                  poll_in      = cfg.spin_limit;
                  phase_in     = pnl_pkg::PH_TX_A;
               end
               pnl_pkg::CmdReceive: begin
                  poll_in  = cfg.spin_limit;
                  phase_in = pnl_pkg::PH_RX_A;
               end
               default: begin
                  // Finish: drive the trailer of the last byte sent, or zero in compatible mode
                  step_dv     = 1'b1;
                  step_dd     = cmp ? 8'h00
                                    : (pnl_pkg::bsd_tx_low(sent_any_ff ? last_sent_ff : 8'h00)
                                       ^ 8'h17);
                  sent_any_in = 1'b0;
               end
            endcase
         end
      end else begin
         unique case (phase_ff)
            pnl_pkg::PH_TX_A: begin
               ok = cmp ? ~shake : shake;
               if (ok) begin
                  step_dv  = 1'b1;
                  step_dd  = cmp ? pnl_pkg::cmp_tx_high(held_ff)
                                 : pnl_pkg::bsd_tx_low(held_ff);
                  poll_in  = cfg.spin_limit;
                  phase_in = pnl_pkg::PH_TX_B;
               end
            end
            pnl_pkg::PH_TX_B: begin
               ok = cmp ? shake : ~shake;
               if (ok) begin
                  step_ev  = pnl_pkg::EvTxDone;
                  phase_in = pnl_pkg::PH_IDLE;
               end
            end
            pnl_pkg::PH_RX_A: begin
               ok = cmp ? ~shake : shake;
               if (ok) begin
                  first_in = st_ff;
                  step_dv  = 1'b1;
                  step_dd  = cmp ? 8'h10 : 8'h08;
                  poll_in  = cfg.spin_limit;
                  phase_in = pnl_pkg::PH_RX_B;
               end else if (!cmp && recv_any_ff && (st_ff != last_second_ff) &&
                            (((st_ff ^ 8'hB8) & 8'hF8) == (last_second_ff & 8'hF8))) begin
                  // Trailer marker seen: end of frame
                  ended       = 1'b1;
                  step_ev     = pnl_pkg::EvFrameEnd;
                  recv_any_in = 1'b0;
                  phase_in    = pnl_pkg::PH_IDLE;
               end
            end
            pnl_pkg::PH_RX_B: begin
               ok = cmp ? shake : ~shake;
               if (ok) begin
                  step_rb        = cmp ? pnl_pkg::cmp_rx(first_ff, st_ff)
                                       : pnl_pkg::bsd_rx(first_ff, st_ff);
                  last_second_in = st_ff;
                  recv_any_in    = 1'b1;
                  step_dv        = 1'b1;
                  step_dd        = 8'h00;
                  step_ev        = pnl_pkg::EvRxDone;
                  phase_in       = pnl_pkg::PH_IDLE;
               end
            end
            default: begin
               ok = 1'b1;
            end
         endcase
         // Count down a failed poll; time out on reaching zero
         if (!ok && !ended && (phase_ff != pnl_pkg::PH_IDLE)) begin
            poll_in = poll_dec;
            if (poll_dec == 16'd0) begin
               step_ev     = pnl_pkg::EvTimeout;
               step_dv     = 1'b1;
               step_dd     = 8'h00;
               recv_any_in = 1'b0;
               phase_in    = pnl_pkg::PH_IDLE;
            end
         end
      end
   end

   // Control and link state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= pnl_pkg::PH_IDLE;
         held_ff        <= 8'h00;
         first_ff       <= 8'h00;
         poll_ff        <= 16'd0;
         last_sent_ff   <= 8'h00;
         sent_any_ff    <= 1'b0;
         last_second_ff <= 8'h00;
         recv_any_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            phase_ff       <= phase_in;
            held_ff        <= held_in;
            first_ff       <= first_in;
            poll_ff        <= poll_in;
            last_sent_ff   <= last_sent_in;
            sent_any_ff    <= sent_any_in;
            last_second_ff <= last_second_in;
            recv_any_ff    <= recv_any_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tuser;
         txb_ff <= req_tdata[7:0];
         st_ff  <= req_tdata[15:8];
      end
      if (adv) begin
         out_data_ff <= {4'h0, step_rb, step_ev, step_dd, step_dv};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Checks
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   a_timeout_idle: assert property (@(posedge clock) disable iff (reset)
      (adv && (step_ev == pnl_pkg::EvTimeout)) |=> (phase_ff == pnl_pkg::PH_IDLE))
      else $error("timeout did not return the link to idle");

   a_busy_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (adv && (step_ev == pnl_pkg::EvBusy)) |=> $stable(phase_ff))
      else $error("rejected request changed the phase");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !adv) |=> in_valid_ff)
      else $error("stalled request dropped");

endmodule

>>> sv/parallel_nibble_link_byte_engine_unit.sv
// Channel   Ports   Direction  Contents
// request   req_*   in         tuser: command; tdata: tx_byte, status_lines
// result    rsp_*   out        tdata: drive_valid, drive_data, event_res, rx_byte
// config    csr_*   in         link_mode at 0x0, spin_limit at 0x4
//
// Each request passes from acceptance into the input register, then through the
// handshake step logic into the result register. One request is accepted every
// cycle unless the result stalls; the link state advances once per request.
// Reset is synchronous and returns the link to idle with registers at defaults.
// A stalled result holds the step logic; requests are taken while the result
// register drains.
module parallel_nibble_link_byte_engine_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // tx_byte[7:0], status_lines[15:8]
   input  logic [1:0]                         req_tuser,  // command[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,  // drive_valid[0], drive_data[8:1],
                                                          // event_res[11:9], rx_byte[19:12]
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pnl_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [pnl_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [pnl_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);

   pnl_pkg::cfg_type cfg;

   pnl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pnl_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] txb;
      logic [7:0] st;
   } link_req_type;

   typedef struct packed {
      logic       dv;
      logic [7:0] dd;
      logic [2:0] ev;
      logic [7:0] rb;
   } link_result_type;

   localparam logic [pnl_pkg::CsrAddrWidth-1:0] AddrLinkMode  =
      {pnl_pkg::CsrIdxLinkMode, 2'b00};
   localparam logic [pnl_pkg::CsrAddrWidth-1:0] AddrSpinLimit =
      {pnl_pkg::CsrIdxSpinLimit, 2'b00};
   localparam int NumSettings = 8;
   localparam int ItemsPerSetting = 140;
   localparam int HoldCycles = 250;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [pnl_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [pnl_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [pnl_pkg::CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   // Link engine state as the checker sees it
   logic        cfg_mode = pnl_pkg::LinkModeReset;
   logic [15:0] cfg_spin = pnl_pkg::SpinLimitReset;
   pnl_pkg::phase_type lk_phase = pnl_pkg::PH_IDLE;
   logic [7:0]  lk_held = '0;
   logic [7:0]  lk_first = '0;
   logic [15:0] lk_polls = '0;
   logic [7:0]  lk_last_sent = '0;
   logic        lk_sent_any = 1'b0;
   logic [7:0]  lk_last_s2 = '0;
   logic        lk_rx_any = 1'b0;

   link_req_type    pending[$];
   link_result_type due_results[$];
   link_req_type    offered;
   logic         no_gaps = 1'b0;
   int           fails = 0;
   int           requests_taken = 0;
   int           results_seen = 0;
   int           hold_left = 0;
   logic         hold_done = 1'b0;
   int           events_seen[8];
   int           queued = 0;

   parallel_nibble_link_byte_engine_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // tx_byte[7:0], status_lines[15:8]
      .req_tuser   (req_tuser),   // command[1:0]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // drive_valid[0], drive_data[8:1], event_res[11:9],
                                  // rx_byte[19:12]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Low nibble of a byte as coded on the data lines in BSD mode
   function automatic logic [7:0] bsd_low_code(input logic [7:0] b);
      return ((b & 8'h08) << 1) | (b & 8'h07);
   endfunction

   // Advance the link state by one request and return the result it causes
   function automatic link_result_type link_step(input link_req_type q);
      link_result_type r;
      logic crm;
      logic shake;
      logic ok;
      logic ended;
      r = '0;
      crm = cfg_mode;
      shake = crm ? q.st[7] : q.st[6];
      ok = 1'b0;
      ended = 1'b0;
      if (q.cmd != pnl_pkg::CmdSample) begin
         if (lk_phase != pnl_pkg::PH_IDLE) begin
            r.ev = pnl_pkg::EvBusy;
         end else if (q.cmd == pnl_pkg::CmdSend) begin
            lk_held = q.txb;
            lk_last_sent = q.txb;
            lk_sent_any = 1'b1;
            r.dv = 1'b1;
            r.dd = crm ? (8'h10 | (q.txb & 8'h0F))
                       : (((q.txb & 8'h80) >> 3) | ((q.txb & 8'h70) >> 4) | 8'h08);
            lk_polls = cfg_spin;
            lk_phase = pnl_pkg::PH_TX_A;
         end else if (q.cmd == pnl_pkg::CmdReceive) begin
            lk_polls = cfg_spin;
            lk_phase = pnl_pkg::PH_RX_A;
         end else begin
            r.dv = 1'b1;
            r.dd = crm ? 8'h00 : (bsd_low_code(lk_sent_any ? lk_last_sent : 8'h00) ^ 8'h17);
            lk_sent_any = 1'b0;
         end
      end else begin
         case (lk_phase)
            pnl_pkg::PH_TX_A: begin
               ok = crm ? !shake : shake;
               if (ok) begin
                  r.dv = 1'b1;
                  r.dd = crm ? (lk_held >> 4) : bsd_low_code(lk_held);
                  lk_polls = cfg_spin;
                  lk_phase = pnl_pkg::PH_TX_B;
               end
            end
            pnl_pkg::PH_TX_B: begin
               ok = crm ? shake : !shake;
               if (ok) begin
                  r.ev = pnl_pkg::EvTxDone;
                  lk_phase = pnl_pkg::PH_IDLE;
               end
            end
            pnl_pkg::PH_RX_A: begin
               ok = crm ? !shake : shake;
               if (ok) begin
                  lk_first = q.st;
                  r.dv = 1'b1;
                  r.dd = crm ? 8'h10 : 8'h08;
                  lk_polls = cfg_spin;
                  lk_phase = pnl_pkg::PH_RX_B;
               end else if (!crm && lk_rx_any && q.st != lk_last_s2 &&
                            ((q.st ^ 8'hB8) & 8'hF8) == (lk_last_s2 & 8'hF8)) begin
                  // trailer marker seen: close the frame
                  ended = 1'b1;
                  r.ev = pnl_pkg::EvFrameEnd;
                  lk_rx_any = 1'b0;
                  lk_phase = pnl_pkg::PH_IDLE;
               end
            end
            pnl_pkg::PH_RX_B: begin
               ok = crm ? shake : !shake;
               if (ok) begin
                  r.rb = crm ? (((lk_first & 8'h78) >> 3) | ((q.st & 8'h78) << 1))
                             : ((~lk_first & 8'h80) | ((lk_first & 8'h38) << 1) |
                                ((~q.st & 8'h80) >> 4) | ((q.st & 8'h38) >> 3));
                  lk_last_s2 = q.st;
                  lk_rx_any = 1'b1;
                  r.dv = 1'b1;
                  r.dd = 8'h00;
                  r.ev = pnl_pkg::EvRxDone;
                  lk_phase = pnl_pkg::PH_IDLE;
               end
            end
            default: ok = 1'b1;
         endcase
         // count the failed poll down; wrap from zero gives a full 65536
         if (!ok && !ended && lk_phase != pnl_pkg::PH_IDLE) begin
            lk_polls = lk_polls - 16'd1;
            if (lk_polls == 16'd0) begin
               r.ev = pnl_pkg::EvTimeout;
               r.dv = 1'b1;
               r.dd = 8'h00;
               lk_rx_any = 1'b0;
               lk_phase = pnl_pkg::PH_IDLE;
            end
         end
      end
      return r;
   endfunction

   // Request driver: present queued requests, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            link_result_type e;
            e = link_step(offered);
            due_results.push_back(e);
            events_seen[e.ev]++;
            requests_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 31)) begin
               offered = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= offered.cmd;
               req_tdata <= {offered.st, offered.txb};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            link_result_type x;
            results_seen++;
            if (due_results.size() == 0) begin
               $error("result with no request waiting: %h", rsp_tdata);
               fails++;
            end else begin
               x = due_results.pop_front();
               if (rsp_tdata[0] !== x.dv) begin
                  $error("drive_valid: expected %0h, got %0h", x.dv, rsp_tdata[0]);
                  fails++;
               end
               if (rsp_tdata[8:1] !== x.dd) begin
                  $error("drive_data: expected %0h, got %0h", x.dd, rsp_tdata[8:1]);
                  fails++;
               end
               if (rsp_tdata[11:9] !== x.ev) begin
                  $error("event_res: expected %0h, got %0h", x.ev, rsp_tdata[11:9]);
                  fails++;
               end
               if (rsp_tdata[19:12] !== x.rb) begin
                  $error("rx_byte: expected %0h, got %0h", x.rb, rsp_tdata[19:12]);
                  fails++;
               end
               if (rsp_tdata[23:20] !== 4'h0) begin
                  $error("padding: expected 0, got %0h", rsp_tdata[23:20]);
                  fails++;
               end
            end
         end
         // hold off once for a long stretch so the request side backs up
         if (results_seen >= 230 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || $urandom_range(0, 99) >= 31;
         end
      end
   end

   task automatic push(input logic [1:0] cmd, input logic [7:0] txb, input logic [7:0] st);
      link_req_type q;
      q.cmd = cmd;
      q.txb = txb;
      q.st = st;
      pending.push_back(q);
      queued++;
   endtask

   // Random status byte with the handshake bit of the mode forced to a level
   function automatic logic [7:0] make_status(input logic m, input logic lvl);
      logic [7:0] s;
      s = 8'($urandom_range(0, 255));
      if (m) s[7] = lvl;
      else s[6] = lvl;
      return s;
   endfunction

   function automatic int pick_fails();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(1, 8);
   endfunction

   // Queue failed polls followed by the sample that completes the wait
   task automatic push_wait(input logic m, input logic lvl, input int nfail,
                            output logic [7:0] s_ok);
      int i;
      for (i = 0; i < nfail; i++)
         push(pnl_pkg::CmdSample, 8'($urandom_range(0, 255)), make_status(m, ~lvl));
      s_ok = make_status(m, lvl);
      push(pnl_pkg::CmdSample, 8'($urandom_range(0, 255)), s_ok);
   endtask

   task automatic csr_write(input logic [pnl_pkg::CsrAddrWidth-1:0] addr,
                            input logic [pnl_pkg::CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Wait until every request is taken and every result checked, then settle
   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((pending.size() != 0 || req_tvalid || due_results.size() != 0) &&
             guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         fails++;
         due_results.delete();
      end
      repeat (6) @(posedge clock);
   endtask

   initial begin
      logic        modes[NumSettings];
      logic [15:0] spins[NumSettings];
      logic [7:0]  s1;
      logic [7:0]  s2;
      logic [7:0]  gen_last_s2;
      logic        m;
      int          k;
      int          j;
      int          r;
      int          start;

      modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      spins = '{16'd65535, 16'd1, 16'd1, 16'd0, 16'd0, 16'd65535, 16'd3, 16'd2};
      gen_last_s2 = 8'h00;
      foreach (events_seen[i]) events_seen[i] = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, BSD mode
      push(pnl_pkg::CmdFinish, 8'h00, 8'h00);     // trailer with nothing sent
      push(pnl_pkg::CmdSample, 8'hFF, 8'hFF);     // sample while idle
      push(pnl_pkg::CmdSend, 8'hFF, 8'h00);
      push(pnl_pkg::CmdSample, 8'h00, 8'h00);     // failed poll
      push(pnl_pkg::CmdSend, 8'h12, 8'h00);       // busy
      push(pnl_pkg::CmdReceive, 8'h00, 8'h00);    // busy
      push(pnl_pkg::CmdFinish, 8'h00, 8'h00);     // busy
      push(pnl_pkg::CmdSample, 8'h00, 8'h40);
      push(pnl_pkg::CmdSample, 8'h00, 8'hFF);     // failed poll
      push(pnl_pkg::CmdSample, 8'h00, 8'hBF);
      push(pnl_pkg::CmdSend, 8'h00, 8'h00);
      push(pnl_pkg::CmdSample, 8'h00, 8'h40);
      push(pnl_pkg::CmdSample, 8'h00, 8'h00);
      push(pnl_pkg::CmdFinish, 8'h00, 8'h00);
      push(pnl_pkg::CmdReceive, 8'h00, 8'h00);
      push(pnl_pkg::CmdSample, 8'h00, 8'hFF);
      push(pnl_pkg::CmdSample, 8'h00, 8'h00);
      push(pnl_pkg::CmdReceive, 8'h00, 8'h00);
      push(pnl_pkg::CmdSample, 8'h00, 8'hB8);     // trailer marker ends the frame
      wait_drained();

      for (k = 0; k < NumSettings; k++) begin
         m = modes[k];
         csr_write(AddrLinkMode, pnl_pkg::CsrDataWidth'(m));
         csr_write(AddrSpinLimit, pnl_pkg::CsrDataWidth'(spins[k]));
         cfg_mode = m;
         cfg_spin = spins[k];
         no_gaps = (k == 5);
         start = queued;
         while (queued - start < ItemsPerSetting) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               // send one byte, sometimes closing the frame
               push(pnl_pkg::CmdSend, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
               push_wait(m, ~m, pick_fails(), s1);
               push_wait(m, m, pick_fails(), s2);
               if ($urandom_range(0, 9) < 3)
                  push(pnl_pkg::CmdFinish, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            end else if (r < 70) begin
               // receive a short frame, then aim at its trailer marker
               for (j = $urandom_range(1, 4); j > 0; j--) begin
                  push(pnl_pkg::CmdReceive, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
                  push_wait(m, ~m, pick_fails(), s1);
                  push_wait(m, m, pick_fails(), s2);
                  gen_last_s2 = s2;
               end
               if ($urandom_range(0, 9) < 7) begin
                  push(pnl_pkg::CmdReceive, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
                  push(pnl_pkg::CmdSample, 8'($urandom_range(0, 255)),
                       ((gen_last_s2 & 8'hF8) ^ 8'hB8) | 8'($urandom_range(0, 7)));
               end
            end else if (r < 85) begin
               push(pnl_pkg::CmdFinish, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
            end else begin
               for (j = $urandom_range(1, 3); j > 0; j--)
                  push(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            end
         end
         // leave a handshake open now and then so the next setting lands mid-transfer
         if ($urandom_range(0, 1) == 1)
            push($urandom_range(0, 1) ? pnl_pkg::CmdSend : pnl_pkg::CmdReceive,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         wait_drained();
      end

      no_gaps = 1'b0;
      wait_drained();
      $display("Checked %0d requests over %0d register settings plus reset defaults.",
               requests_taken, NumSettings);
      $display("Events: tx done %0d, rx done %0d, timeout %0d, frame end %0d, busy %0d.",
               events_seen[pnl_pkg::EvTxDone], events_seen[pnl_pkg::EvRxDone],
               events_seen[pnl_pkg::EvTimeout], events_seen[pnl_pkg::EvFrameEnd],
               events_seen[pnl_pkg::EvBusy]);
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Stop a run that hangs
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
